>>> rtl/core/deq_pkg.sv
`default_nettype none

package deq_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SEARCH     = 3'd4,
    CMD_DUMP       = 3'd5,
    CMD_COUNT      = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE     = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_ELEM     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_SHR,
    OP_SHL,
    OP_WRITE,
    OP_MARK,
    OP_ROT
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic [CNT_W-1:0]          count;
    logic signed [DATA_W-1:0]  key;
    logic                      match_all;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> rtl/core/deq_cell.sv
`default_nettype none

module deq_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  deq_pkg::cell_ctl_t                ctl_i,
  input  logic [deq_pkg::IDX_W-1:0]         cell_idx_i,
  input  logic signed [deq_pkg::DATA_W-1:0] left_data_i,
  input  logic signed [deq_pkg::DATA_W-1:0] right_data_i,
  input  logic                              right_hit_i,
  input  logic signed [deq_pkg::DATA_W-1:0] head_data_i,
  output logic signed [deq_pkg::DATA_W-1:0] data_o,
  output logic                              hit_o
);
  import deq_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;
  logic                     hit_q, hit_d;
  logic [CNT_W-1:0]         idx_nx;
  logic                     is_tail, in_use;

  // Position one past this cell, so that "this is the last used cell"
  // needs no subtraction from the count.
  assign idx_nx  = CNT_W'(cell_idx_i) + CNT_W'(1);
  assign is_tail = (idx_nx == ctl_i.count);
  assign in_use  = (idx_nx <= ctl_i.count);

  always_comb begin
    data_d = data_q;
    hit_d  = hit_q;
    unique case (ctl_i.op)
      OP_SHR:   data_d = left_data_i;
      OP_SHL:   data_d = right_data_i;
      OP_WRITE: begin
        if (CNT_W'(cell_idx_i) == ctl_i.count) data_d = ctl_i.key;
      end
      OP_MARK:  hit_d = in_use && (ctl_i.match_all || (data_q == ctl_i.key));
      OP_ROT: begin
        // The used part of the row turns by one; the entry leaving the head
        // wraps to the tail with its hit spent.
        if (is_tail) begin
          data_d = head_data_i;
          hit_d  = 1'b0;
        end else if (in_use) begin
          data_d = right_data_i;
          hit_d  = right_hit_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

`default_nettype wire

>>> rtl/core/deque_with_search_top.sv
// Double-ended queue of signed 32-bit values, up to CAPACITY entries, held in
// a row of cells with the front entry in the first cell. Commands are taken
// one at a time over a valid/ready pair. Push, pop, count and clear finish in
// the cycle they are accepted and give a single result item. Search and dump
// mark the entries in the cycle they are accepted and then turn the used part
// of the row once through the head cell, one entry per cycle except while a
// matching entry waits at the head for the output register; a search that
// finds nothing loads its not-found item in the cycle after it is accepted. A
// new command is accepted only when the walk is over and the output register
// is free or being read.
`default_nettype none

module deque_with_search_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2:0]                        cmd_i,
  input  logic signed [deq_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        status_o,
  output logic signed [deq_pkg::DATA_W-1:0] item_value_o,
  output logic [5:0]                        position_o,
  output logic [5:0]                        count_o,
  output logic                              last_o
);
  import deq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [CNT_W-1:0]         walk_q, walk_d;
  logic                     found_q, found_d;
  logic                     out_valid_q, out_valid_d;
  status_e                  status_q, status_d;
  logic signed [DATA_W-1:0] value_q, value_d;
  logic [CNT_W-1:0]         pos_q, pos_d;
  logic [CNT_W-1:0]         cnt_out_q, cnt_out_d;
  logic                     last_q, last_d;

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_hit;
  cell_ctl_t                ctl;

  cmd_e                     cmd;
  logic                     slot_free, accept, is_full, is_empty;
  logic                     head_hit, rest_hit, any_hit, step;
  logic [CNT_W-1:0]         cnt_dec, walk_nx;
  logic [IDX_W-1:0]         tail_idx;

  assign cmd       = cmd_e'(cmd_i);
  assign slot_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && slot_free;
  assign accept    = in_valid_i && in_ready_o;
  assign is_full   = (cnt_q == CNT_W'(CAPACITY));
  assign is_empty  = (cnt_q == '0);
  assign cnt_dec   = cnt_q - CNT_W'(1);
  assign tail_idx  = cnt_dec[IDX_W-1:0];
  assign walk_nx   = walk_q + CNT_W'(1);

  assign head_hit  = cell_hit[0];
  assign rest_hit  = |cell_hit[CAPACITY-1:1];
  assign any_hit   = head_hit || rest_hit;
  // A non-matching entry passes the head without waiting on the output.
  assign step      = (state_q == S_WALK) && (any_hit || found_q)
                     && (!head_hit || slot_free);

  always_comb begin
    ctl.op        = OP_HOLD;
    ctl.count     = cnt_q;
    ctl.key       = value_i;
    ctl.match_all = (cmd == CMD_DUMP);
    if (accept) begin
      unique case (cmd)
        CMD_PUSH_FRONT: if (!is_full) ctl.op = OP_SHR;
        CMD_PUSH_BACK:  if (!is_full) ctl.op = OP_WRITE;
        CMD_POP_FRONT:  if (!is_empty) ctl.op = OP_SHL;
        CMD_SEARCH,
        CMD_DUMP:       if (!is_empty) ctl.op = OP_MARK;
        default:        ctl.op = OP_HOLD;
      endcase
    end else if (step) begin
      ctl.op = OP_ROT;
    end
  end

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic signed [DATA_W-1:0] left_data, right_data;
    logic                     right_hit;
    if (j == 0) begin : g_first
      assign left_data = value_i;
    end else begin : g_mid
      assign left_data = cell_data[j-1];
    end
    if (j == CAPACITY - 1) begin : g_last
      assign right_data = '0;
      assign right_hit  = 1'b0;
    end else begin : g_inner
      assign right_data = cell_data[j+1];
      assign right_hit  = cell_hit[j+1];
    end

    deq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .cell_idx_i   (IDX_W'(j)),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .right_hit_i  (right_hit),
      .head_data_i  (cell_data[0]),
      .data_o       (cell_data[j]),
      .hit_o        (cell_hit[j])
    );
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    walk_d      = walk_q;
    found_d     = found_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    value_d     = value_q;
    pos_d       = pos_q;
    cnt_out_d   = cnt_out_q;
    last_d      = last_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_valid_d = 1'b1;
          status_d    = ST_DONE;
          value_d     = '0;
          pos_d       = '0;
          last_d      = 1'b1;
          cnt_out_d   = cnt_q;
          unique case (cmd)
            CMD_PUSH_FRONT,
            CMD_PUSH_BACK: begin
              if (is_full) begin
                status_d = ST_FULL;
              end else begin
                cnt_d     = cnt_q + CNT_W'(1);
                cnt_out_d = cnt_q + CNT_W'(1);
              end
            end
            CMD_POP_FRONT,
            CMD_POP_BACK: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                cnt_d     = cnt_dec;
                cnt_out_d = cnt_dec;
                value_d   = (cmd == CMD_POP_FRONT) ? cell_data[0]
                                                   : cell_data[tail_idx];
              end
            end
            CMD_SEARCH,
            CMD_DUMP: begin
              if (is_empty) begin
                status_d = ST_EMPTY;
              end else begin
                out_valid_d = 1'b0;
                state_d     = S_WALK;
                walk_d      = '0;
                found_d     = 1'b0;
              end
            end
            CMD_COUNT: ;
            CMD_CLEAR: begin
              cnt_d     = '0;
              cnt_out_d = '0;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (!any_hit && !found_q) begin
          // Nothing matched and the row has not moved yet.
          if (slot_free) begin
            out_valid_d = 1'b1;
            status_d    = ST_NOTFOUND;
            value_d     = '0;
            pos_d       = '0;
            cnt_out_d   = cnt_q;
            last_d      = 1'b1;
            state_d     = S_IDLE;
          end
        end else if (step) begin
          if (head_hit) begin
            out_valid_d = 1'b1;
            status_d    = ST_ELEM;
            value_d     = cell_data[0];
            pos_d       = walk_nx;
            cnt_out_d   = cnt_q;
            last_d      = !rest_hit;
            found_d     = 1'b1;
          end
          walk_d = walk_nx;
          if (walk_nx == cnt_q) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      walk_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= ST_DONE;
      value_q     <= '0;
      pos_q       <= '0;
      cnt_out_q   <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      walk_q      <= walk_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      value_q     <= value_d;
      pos_q       <= pos_d;
      cnt_out_q   <= cnt_out_d;
      last_q      <= last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign item_value_o = value_q;
  assign position_o   = 6'(pos_q);
  assign count_o      = 6'(cnt_out_q);
  assign last_o       = last_q;

endmodule

`default_nettype wire

>>> rtl/core/deq_checker.sv
`default_nettype none

module deq_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_o,
  input  logic [2:0]                        cmd_i,
  input  logic                              out_valid_o,
  input  logic                              out_ready_i,
  input  logic [2:0]                        status_o,
  input  logic signed [deq_pkg::DATA_W-1:0] item_value_o,
  input  logic [5:0]                        position_o,
  input  logic                              last_o
);
  import deq_pkg::*;

  // Every command other than search and dump answers in the next cycle.
  a_single_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && cmd_i != CMD_SEARCH && cmd_i != CMD_DUMP)
    |=> out_valid_o)
    else $error("single-result command gave no result item");

  // Only matches and dumped entries can be followed by more items.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_ELEM) |-> last_o)
    else $error("non-element result item without last");

  a_elem_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_ELEM) |-> (position_o != 6'd0))
    else $error("element result item without position");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(item_value_o)
      && $stable(status_o) && $stable(last_o)))
    else $error("stalled result item changed");

endmodule

bind deque_with_search_top deq_checker u_deq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .cmd_i        (cmd_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .item_value_o (item_value_o),
  .position_o   (position_o),
  .last_o       (last_o)
);

`default_nettype wire

>>> tb/deque_sb_pkg.sv
`timescale 1ns / 1ps

package deque_sb_pkg;

  import deq_pkg::*;

  typedef struct {
    status_e                  status;
    logic signed [DATA_W-1:0] item_value;
    logic [5:0]               position;
    logic [5:0]               count;
    logic                     last;
  } deque_result_t;

  // Keeps its own copy of the ring and queues the results that each accepted
  // command must produce, in order.
  class deque_scoreboard;
    logic signed [DATA_W-1:0] ring[CAPACITY];
    int unsigned              head;
    int unsigned              fill;
    deque_result_t            awaited_q[$];
    int unsigned              errors;

    function new();
      head   = 0;
      fill   = 0;
      errors = 0;
      foreach (ring[i]) ring[i] = '0;
    endfunction

    function int unsigned slot(int unsigned ofs);
      return (head + ofs) % CAPACITY;
    endfunction

    function int unsigned pending();
      return awaited_q.size();
    endfunction

    function int unsigned held();
      return fill;
    endfunction

    // A value that is currently stored (a random one if none is), so that searches find matches.
    function logic signed [DATA_W-1:0] pick_held();
      if (fill == 0) return $urandom;
      return ring[slot($urandom_range(0, fill - 1))];
    endfunction

    function void queue_result(status_e st, logic signed [DATA_W-1:0] v,
                               int unsigned pos, logic lst);
      deque_result_t r;
      r.status     = st;
      r.item_value = v;
      r.position   = pos[5:0];
      r.count      = fill[5:0];
      r.last       = lst;
      awaited_q.push_back(r);
    endfunction

    function void note_command(cmd_e cmd, logic signed [DATA_W-1:0] val);
      logic signed [DATA_W-1:0] v;
      int unsigned              hits;
      hits = 0;
      case (cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (fill >= CAPACITY) begin
            queue_result(ST_FULL, '0, 0, 1'b1);
          end else begin
            if (cmd == CMD_PUSH_FRONT) begin
              head       = (head == 0) ? CAPACITY - 1 : head - 1;
              ring[head] = val;
            end else begin
              ring[slot(fill)] = val;
            end
            fill++;
            queue_result(ST_DONE, '0, 0, 1'b1);
          end
        end
        CMD_POP_FRONT, CMD_POP_BACK: begin
          if (fill == 0) begin
            queue_result(ST_EMPTY, '0, 0, 1'b1);
          end else begin
            if (cmd == CMD_POP_FRONT) begin
              v    = ring[head];
              head = slot(1);
            end else begin
              v = ring[slot(fill - 1)];
            end
            fill--;
            queue_result(ST_DONE, v, 0, 1'b1);
          end
        end
        CMD_SEARCH, CMD_DUMP: begin
          if (fill == 0) begin
            queue_result(ST_EMPTY, '0, 0, 1'b1);
          end else begin
            for (int unsigned i = 0; i < fill; i++) begin
              v = ring[slot(i)];
              if (cmd == CMD_DUMP || v == val) begin
                queue_result(ST_ELEM, v, i + 1, 1'b0);
                hits++;
              end
            end
            if (hits == 0) queue_result(ST_NOTFOUND, '0, 0, 1'b1);
            else awaited_q[awaited_q.size() - 1].last = 1'b1;
          end
        end
        CMD_COUNT: begin
          queue_result(ST_DONE, '0, 0, 1'b1);
        end
        default: begin
          head = 0;
          fill = 0;
          queue_result(ST_DONE, '0, 0, 1'b1);
        end
      endcase
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want,
                                logic [DATA_W-1:0] got);
      if (want !== got) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [2:0] status, logic signed [DATA_W-1:0] item_value,
                               logic [5:0] position, logic [5:0] count, logic last);
      deque_result_t r;
      if (awaited_q.size() == 0) begin
        $error("result item with none awaited: status %0d value 0x%0h", status, item_value);
        errors++;
        return;
      end
      r = awaited_q.pop_front();
      compare_field("status", 32'(r.status), 32'(status));
      compare_field("item_value", r.item_value, item_value);
      compare_field("position", 32'(r.position), 32'(position));
      compare_field("count", 32'(r.count), 32'(count));
      compare_field("last", 32'(r.last), 32'(last));
    endfunction
  endclass

endpackage

>>> tb/tb_deque_with_search_top.sv
`timescale 1ns / 1ps

module tb_deque_with_search_top;

  import deq_pkg::*;
  import deque_sb_pkg::*;

  localparam int RANDOM_ITEMS = 310;
  localparam int PHASE_LEN    = 40;
  localparam int MODE_FILL    = 0;
  localparam int MODE_DRAIN   = 1;
  localparam int MODE_MIX     = 2;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_ready_o;
  logic [2:0]               cmd_i       = CMD_COUNT;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [2:0]               status_o;
  logic signed [DATA_W-1:0] item_value_o;
  logic [5:0]               position_o;
  logic [5:0]               count_o;
  logic                     last_o;

  deque_scoreboard sb;
  int unsigned     rx_cycle = 0;
  int unsigned     rx_mode  = 0;
  int unsigned     burst_left = 0;

  deque_with_search_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .item_value_o (item_value_o),
    .position_o   (position_o),
    .count_o      (count_o),
    .last_o       (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // The receiver switches between several stall patterns, chosen at random.
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= 1'($urandom_range(0, 1));
      2:       out_ready_i <= (rx_cycle % 5) < 3;
      default: out_ready_i <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result(status_o, item_value_o, position_o, count_o, last_o);
      if (in_valid_i && in_ready_o) sb.note_command(cmd_e'(cmd_i), value_i);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high.
  task automatic send_item(cmd_e c, logic signed [DATA_W-1:0] v);
    in_valid_i <= 1'b1;
    cmd_i      <= c;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic idle_for(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Bursts of random length, sometimes long, with random gaps between them.
  task automatic paced_send(cmd_e c, logic signed [DATA_W-1:0] v);
    if (burst_left == 0) begin
      idle_for($urandom_range(1, 8));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    send_item(c, v);
  endtask

  function automatic logic signed [DATA_W-1:0] any_value();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return $signed($urandom_range(0, 7)) - 4;
      2: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh8000_0000;
          1:       return 32'sh7fff_ffff;
          2:       return '0;
          default: return -1;
        endcase
      end
      default: return sb.pick_held();
    endcase
  endfunction

  task automatic next_command(int mode, output cmd_e c,
                              output logic signed [DATA_W-1:0] v);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mode)
      MODE_FILL: begin
        if (r < 43)      c = CMD_PUSH_FRONT;
        else if (r < 86) c = CMD_PUSH_BACK;
        else if (r < 92) c = CMD_SEARCH;
        else if (r < 96) c = CMD_COUNT;
        else             c = CMD_DUMP;
      end
      MODE_DRAIN: begin
        if (r < 37)      c = CMD_POP_FRONT;
        else if (r < 75) c = CMD_POP_BACK;
        else if (r < 85) c = CMD_SEARCH;
        else if (r < 92) c = CMD_DUMP;
        else             c = CMD_COUNT;
      end
      default: begin
        if (r < 18)      c = CMD_PUSH_FRONT;
        else if (r < 36) c = CMD_PUSH_BACK;
        else if (r < 48) c = CMD_POP_FRONT;
        else if (r < 60) c = CMD_POP_BACK;
        else if (r < 80) c = CMD_SEARCH;
        else if (r < 88) c = CMD_DUMP;
        else if (r < 95) c = CMD_COUNT;
        else             c = CMD_CLEAR;
      end
    endcase
    if (c == CMD_SEARCH && $urandom_range(0, 9) < 7) v = sb.pick_held();
    else v = any_value();
  endtask

  initial begin
    #4_000_000;
    $display("** deque_with_search_top: FAILED **");
    $finish;
  end

  initial begin
    cmd_e                     c;
    logic signed [DATA_W-1:0] v;
    int                       mode;
    sb = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty store first, then extremes, duplicates, misses and a clear of a
    // store that still holds an entry.
    send_item(CMD_COUNT, 32'sd0);
    send_item(CMD_POP_FRONT, 32'sd0);
    send_item(CMD_POP_BACK, 32'sd0);
    send_item(CMD_SEARCH, 32'sd0);
    send_item(CMD_DUMP, 32'sd0);
    send_item(CMD_PUSH_BACK, 32'sh7fff_ffff);
    send_item(CMD_PUSH_FRONT, 32'sh8000_0000);
    send_item(CMD_PUSH_BACK, 32'sd0);
    send_item(CMD_PUSH_FRONT, -32'sd1);
    send_item(CMD_PUSH_BACK, 32'sh7fff_ffff);
    send_item(CMD_SEARCH, 32'sh7fff_ffff);
    send_item(CMD_SEARCH, 32'sd12345);
    send_item(CMD_DUMP, 32'sd0);
    send_item(CMD_COUNT, 32'sd0);
    send_item(CMD_POP_FRONT, 32'sd0);
    send_item(CMD_POP_BACK, 32'sd0);
    send_item(CMD_POP_FRONT, 32'sd0);
    send_item(CMD_POP_BACK, 32'sd0);
    send_item(CMD_CLEAR, 32'sd0);
    send_item(CMD_DUMP, 32'sd0);
    send_item(CMD_PUSH_FRONT, 32'sd5);
    send_item(CMD_POP_BACK, 32'sd0);
    wait_drained();

    mode = MODE_FILL;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k > 0 && k % PHASE_LEN == 0) begin
        mode = $urandom_range(MODE_FILL, MODE_MIX);
        if ($urandom_range(0, 2) == 0) wait_drained();
      end
      next_command(mode, c, v);
      paced_send(c, v);
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4 * CAPACITY) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("** deque_with_search_top: PASSED **");
    end else begin
      $display("** deque_with_search_top: FAILED **");
    end
    $finish;
  end

endmodule
